### rtl/core/hpg_pkg.sv
`default_nettype none

package hpg_pkg;

  // fixed field widths
  localparam int IDX_W       = 31;
  localparam int COORD_W     = 32;
  localparam int DIM_NUM_W   = 3;
  localparam int CFG_W       = 4;

  // digit step datapath
  localparam int DIGIT_W     = 6;
  localparam int DEN_W       = 37;
  localparam int RECIP_W     = 33;
  localparam int SHIFT_W     = 3;
  localparam int PRIME_COUNT = 16;

  // parameter defaults
  localparam int MAX_DIMS_DEF      = 8;
  localparam int FRACTION_BITS_DEF = 32;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_DIMS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] DIMS_RESET = 4'd1;

  // prime bases in dimension order
  localparam logic [DIGIT_W-1:0] PRIME_TABLE [PRIME_COUNT] = '{
    6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19,
    6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
  };

  // ceil(log2(base)); the reciprocal scale is 2^(IDX_W + this)
  localparam logic [SHIFT_W-1:0] SHIFT_TABLE [PRIME_COUNT] = '{
    3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
  };

  // floor(2^(IDX_W + shift) / base) + 1, exact quotient for any index
  localparam logic [RECIP_W-1:0] RECIP_TABLE [PRIME_COUNT] = '{
    33'((64'd1 << 32) / 64'd2  + 64'd1),
    33'((64'd1 << 33) / 64'd3  + 64'd1),
    33'((64'd1 << 34) / 64'd5  + 64'd1),
    33'((64'd1 << 34) / 64'd7  + 64'd1),
    33'((64'd1 << 35) / 64'd11 + 64'd1),
    33'((64'd1 << 35) / 64'd13 + 64'd1),
    33'((64'd1 << 36) / 64'd17 + 64'd1),
    33'((64'd1 << 36) / 64'd19 + 64'd1),
    33'((64'd1 << 36) / 64'd23 + 64'd1),
    33'((64'd1 << 36) / 64'd29 + 64'd1),
    33'((64'd1 << 36) / 64'd31 + 64'd1),
    33'((64'd1 << 37) / 64'd37 + 64'd1),
    33'((64'd1 << 37) / 64'd41 + 64'd1),
    33'((64'd1 << 37) / 64'd43 + 64'd1),
    33'((64'd1 << 37) / 64'd47 + 64'd1),
    33'((64'd1 << 37) / 64'd53 + 64'd1)
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_DIGIT,
    ST_DIV,
    ST_EMIT
  } hpg_state_t;

endpackage

`default_nettype wire

### rtl/core/hpg_if.sv
`default_nettype none

// index channel
interface hpg_in_if;
  import hpg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

// coordinate channel
interface hpg_out_if;
  import hpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   coordinate;
  logic [DIM_NUM_W-1:0] dim_number;
  logic                 last;
  modport source (output valid, output coordinate, output dim_number, output last,
                  input ready);
  modport sink   (input valid, input coordinate, input dim_number, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/halton_point_generator.sv
`default_nettype none

// Halton point generator.
// An item on in_chan carries a sequence index; for it the block sends one item per
// dimension in use on out_chan: the radical inverse of the index in that
// dimension's prime base as an unsigned 0.32 fraction, the dimension number, and
// last on the final dimension. dims_in_use sits at byte address 0 of the register
// port (0 acts as 1, values above MAX_DIMS as MAX_DIMS); write it only when idle.
// Each dimension goes through the start state, then one base-b digit of the index
// per pass through the reciprocal multiplier (multiply state, then digit state),
// then one fraction bit per cycle from the restoring divider, then the emit state.
// Index 0 skips the digit loop. An index is taken only in the idle state, so
// in_chan is ready only between items.
// Each coordinate goes into an output register and work on the next dimension
// goes on while it waits; a stalled receiver holds the sequencer only when the
// next coordinate is ready to leave. The register stays in front of the next
// item, so a new index is taken while the last coordinate is still held.
// Reset sets dims_in_use to 1 and empties the output register.
module halton_point_generator #(
  parameter int MAX_DIMS      = hpg_pkg::MAX_DIMS_DEF,
  parameter int FRACTION_BITS = hpg_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hpg_in_if.sink                     in_chan,
  hpg_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hpg_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [hpg_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [hpg_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hpg_pkg::*;

  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int BIT_W  = $clog2(FRACTION_BITS);
  localparam int TAB_W  = $clog2(PRIME_COUNT);
  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int QB_W   = IDX_W + DIGIT_W;
  localparam int SH_W   = $clog2(PROD_W);

  hpg_state_t state_r, state_nxt;

  logic [CFG_W-1:0]         dims_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         n_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DEN_W-1:0]         mirr_r;
  logic [DEN_W-1:0]         den_r;
  logic [FRACTION_BITS-1:0] quo_r;
  logic [BIT_W-1:0]         bit_r;
  logic [DIM_W-1:0]         dim_r;
  logic [DIM_W-1:0]         last_dim_r;
  logic                     out_valid_r;
  logic [COORD_W-1:0]       out_coord_r;
  logic [DIM_NUM_W-1:0]     out_dim_r;
  logic                     out_last_r;

  logic                 in_ready_c;
  logic                 out_load_c;
  logic                 accept_c;
  logic                 cfg_wr_c;
  logic [CFG_W:0]       dims_cnt_c;
  logic [DIM_W-1:0]     last_dim_c;
  logic [TAB_W-1:0]     tab_idx_c;
  logic [DIGIT_W-1:0]   base_c;
  logic [SH_W-1:0]      shamt_c;
  logic [IDX_W-1:0]     quo_c;
  logic [QB_W-1:0]      qb_c;
  logic [DIGIT_W-1:0]   digit_c;
  logic [DEN_W-1:0]     mirr_step_c;
  logic [DEN_W-1:0]     den_step_c;
  logic [DEN_W:0]       rem_sh_c;
  logic                 rem_ge_c;
  logic [DEN_W:0]       rem_nxt_c;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr_c   = cfg_psel & cfg_penable & cfg_pwrite
                      & (cfg_paddr[APB_AW-1] == REG_DIMS_IN_USE);
  assign cfg_prdata = (cfg_paddr[APB_AW-1] == REG_DIMS_IN_USE) ? APB_DW'(dims_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
    end else if (cfg_wr_c) begin
      dims_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // clamp the dimension count to 1..MAX_DIMS
  always_comb begin
    if (dims_r == '0) begin
      dims_cnt_c = (CFG_W+1)'(1);
    end else if ({1'b0, dims_r} > (CFG_W+1)'(MAX_DIMS)) begin
      dims_cnt_c = (CFG_W+1)'(MAX_DIMS);
    end else begin
      dims_cnt_c = {1'b0, dims_r};
    end
    last_dim_c = DIM_W'(dims_cnt_c - (CFG_W+1)'(1));
  end

  // per-base constants
  assign tab_idx_c = TAB_W'(dim_r);
  assign base_c    = PRIME_TABLE[tab_idx_c];
  assign shamt_c   = SH_W'(IDX_W) + SH_W'(SHIFT_TABLE[tab_idx_c]);

  // digit step: quotient from the registered product, digit is what is left
  assign quo_c       = IDX_W'(prod_r >> shamt_c);
  assign qb_c        = QB_W'(quo_c) * QB_W'(base_c);
  assign digit_c     = DIGIT_W'(n_r - IDX_W'(qb_c));
  assign mirr_step_c = DEN_W'(mirr_r * DEN_W'(base_c)) + DEN_W'(digit_c);
  assign den_step_c  = DEN_W'(den_r * DEN_W'(base_c));

  // one restoring division step per cycle
  assign rem_sh_c  = {mirr_r, 1'b0};
  assign rem_ge_c  = rem_sh_c >= {1'b0, den_r};
  assign rem_nxt_c = rem_ge_c ? rem_sh_c - {1'b0, den_r} : rem_sh_c;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = (idx_r == '0) ? ST_DIV : ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        state_nxt = (quo_c == '0) ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (bit_r == BIT_W'(FRACTION_BITS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load_c) state_nxt = (dim_r == last_dim_r) ? ST_IDLE : ST_START;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_c = (state_r == ST_IDLE);
    out_load_c = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  end

  assign in_chan.ready = in_ready_c;
  assign accept_c      = in_chan.valid & in_ready_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept_c) begin
      idx_r      <= in_chan.index;
      dim_r      <= '0;
      last_dim_r <= last_dim_c;
    end
    unique case (state_r)
      ST_START: begin
        n_r    <= idx_r;
        mirr_r <= '0;
        den_r  <= DEN_W'(1);
        bit_r  <= '0;
      end
      ST_MUL: begin
        prod_r <= PROD_W'(n_r) * PROD_W'(RECIP_TABLE[tab_idx_c]);
      end
      ST_DIGIT: begin
        n_r    <= quo_c;
        mirr_r <= mirr_step_c;
        den_r  <= den_step_c;
      end
      ST_DIV: begin
        mirr_r <= DEN_W'(rem_nxt_c);
        quo_r  <= {quo_r[FRACTION_BITS-2:0], rem_ge_c};
        bit_r  <= bit_r + BIT_W'(1);
      end
      ST_EMIT: begin
        if (out_load_c && (dim_r != last_dim_r)) dim_r <= dim_r + DIM_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_c) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_c) begin
      out_coord_r <= COORD_W'(quo_r);
      out_dim_r   <= DIM_NUM_W'(dim_r);
      out_last_r  <= (dim_r == last_dim_r);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.coordinate = out_coord_r;
  assign out_chan.dim_number = out_dim_r;
  assign out_chan.last       = out_last_r;

endmodule

`default_nettype wire

### sim/halton_point_generator_tb.sv
`timescale 1ns / 100ps

module halton_point_generator_tb;
  import hpg_pkg::*;

  localparam int DIM_LIMIT = MAX_DIMS_DEF;
  localparam int unsigned PRIME_BASES [8] = '{2, 3, 5, 7, 11, 13, 17, 19};
  localparam logic [APB_AW-1:0] ADDR_DIMS  = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 600;

  typedef struct packed {
    logic [COORD_W-1:0]   coordinate;
    logic [DIM_NUM_W-1:0] dim_number;
    logic                 last;
  } coord_t;

  typedef enum logic {ROW_WRITE, ROW_INDEX} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [APB_AW-1:0]  addr;
    logic [APB_DW-1:0]  data;
    logic [IDX_W-1:0]   index;
    logic               typed;
    logic [COORD_W-1:0] first_coord;
  } directed_row_t;

  // directed rows: a typed first coordinate where it is obvious
  directed_row_t directed_rows [24] = '{
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h0000_0001, 1'b1, 32'h8000_0000},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h4000_0000, 1'b1, 32'h0000_0002},
    '{ROW_WRITE, ADDR_DIMS, 32'd8, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h0000_0001, 1'b1, 32'h8000_0000},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h5555_5555, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h2AAA_AAAA, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'd12345, 1'b0, 32'h0},
    // zero dimensions acts as one
    '{ROW_WRITE, ADDR_DIMS, 32'd0, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'd5, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    // fifteen saturates to the dimension limit, upper data bits dropped
    '{ROW_WRITE, ADDR_DIMS, 32'hFFFF_FFFF, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'd2, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h7FFF_FFFF, 1'b0, 32'h0},
    // write to an unknown register leaves the setting alone
    '{ROW_WRITE, ADDR_SPARE, 32'd3, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'd7, 1'b0, 32'h0},
    '{ROW_WRITE, ADDR_DIMS, 32'd9, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'd100, 1'b0, 32'h0},
    '{ROW_WRITE, ADDR_DIMS, 32'd3, 31'h0, 1'b0, 32'h0},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h0000_0001, 1'b1, 32'h8000_0000},
    '{ROW_INDEX, ADDR_DIMS, 32'd0, 31'h3FFF_FFFF, 1'b0, 32'h0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  hpg_in_if  in_if ();
  hpg_out_if out_if ();

  coord_t         pending_coords [$];
  logic [CFG_W-1:0] dims_setting;
  int unsigned    failures = 0;
  bit             tx_idle;
  bit             rx_idle;
  bit             hold_request;

  halton_point_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // digits of the index mirrored about the radix point, truncated to 0.32
  function automatic logic [COORD_W-1:0] halton_coordinate(input logic [IDX_W-1:0] idx,
                                                           input longint unsigned base);
    longint unsigned n;
    longint unsigned mirrored;
    longint unsigned denom;
    longint unsigned rem;
    logic [COORD_W-1:0] frac;
    n = idx;
    mirrored = 0;
    denom = 1;
    while (n > 0) begin
      mirrored = mirrored * base + n % base;
      denom = denom * base;
      n = n / base;
    end
    rem = mirrored;
    frac = '0;
    for (int i = 0; i < COORD_W; i++) begin
      rem = rem << 1;
      frac = {frac[COORD_W-2:0], 1'b0};
      if (rem >= denom) begin
        rem = rem - denom;
        frac[0] = 1'b1;
      end
    end
    return frac;
  endfunction

  // queue the coordinates of one accepted index
  task automatic predict_point(input logic [IDX_W-1:0] idx, input logic typed,
                               input logic [COORD_W-1:0] first_coord);
    int count;
    coord_t c;
    count = dims_setting;
    if (count < 1) count = 1;
    if (count > DIM_LIMIT) count = DIM_LIMIT;
    for (int d = 0; d < count; d++) begin
      c.coordinate = (typed && d == 0) ? first_coord : halton_coordinate(idx, PRIME_BASES[d]);
      c.dim_number = DIM_NUM_W'(d);
      c.last       = (d + 1 == count);
      pending_coords = {pending_coords, c};
    end
  endtask

  // offer one index, called and returning at a falling edge
  task automatic offer_index(input logic [IDX_W-1:0] idx, input logic typed,
                             input logic [COORD_W-1:0] first_coord);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.index <= idx;
    do @(posedge clk); while (!in_if.ready);
    predict_point(idx, typed, first_coord);
    @(negedge clk);
  endtask

  // wait for every outstanding coordinate, then a few quiet cycles
  task automatic settle(input int unsigned pad);
    in_if.valid <= 1'b0;
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (pad) @(negedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_DIMS) dims_setting = data[CFG_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // index mix: small values, full range, near all ones, single bits
  function automatic logic [IDX_W-1:0] random_index();
    logic [IDX_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = IDX_W'($urandom_range(0, 15));
      1: v = IDX_W'($urandom_range(0, 4095));
      2: v = IDX_W'($urandom_range(0, 1_000_000));
      3: v = {IDX_W{1'b1}} ^ (IDX_W'(1) << $urandom_range(0, IDX_W - 1));
      4: v = IDX_W'(1) << $urandom_range(0, IDX_W - 1);
      default: v = IDX_W'($urandom());
    endcase
    return v;
  endfunction

  // result side: random ready gaps and one long hold-off
  initial begin : receiver
    int unsigned gap;
    bit hold_done;
    out_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        gap = rx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      @(negedge clk);
    end
  end

  // compare each coordinate item with the oldest expectation
  always @(posedge clk) begin : check_coordinates
    coord_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_coords.size() == 0) begin
        $error("coordinate item with none expected: coordinate %h dim %0d last %0b",
               out_if.coordinate, out_if.dim_number, out_if.last);
        failures++;
      end else begin
        want = pending_coords.pop_front();
        if (out_if.coordinate !== want.coordinate) begin
          $error("coordinate: expected %h, actual %h", want.coordinate, out_if.coordinate);
          failures++;
        end
        if (out_if.dim_number !== want.dim_number) begin
          $error("dim_number: expected %0d, actual %0d", want.dim_number, out_if.dim_number);
          failures++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_if.last);
          failures++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    logic [APB_DW-1:0] data;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_if.valid  = 1'b0;
    in_if.index  = '0;
    dims_setting = DIMS_RESET;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_request = 1'b0;
    sent         = 0;
    phase        = 0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle(4);
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        offer_index(directed_rows[i].index, directed_rows[i].typed,
                    directed_rows[i].first_coord);
      end
    end

    // random phases, each under a fresh setting
    while (sent < RANDOM_ITEMS) begin
      settle(4);
      data = $urandom();
      data[CFG_W-1:0] = CFG_W'($urandom_range(0, 15));
      write_reg(ADDR_DIMS, data);
      if ($urandom_range(0, 3) == 0) write_reg(ADDR_SPARE, $urandom());
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // back pressure: receiver holds off while indices keep coming
      if (phase == 1) begin
        hold_request = 1'b1;
        tx_idle = 1'b0;
      end
      n = $urandom_range(15, 40);
      repeat (n) begin
        offer_index(random_index(), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    settle(TAIL_CYCLES);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
